@@ design/gtbp_pkg.sv @@
// Shared types, constants and helper functions for the grey threshold bit packer.
// Used by gtbp_cfg_regs, gtbp_core and grey_threshold_bit_packer_top.
`timescale 1ns / 1ps

package gtbp_pkg;

    // Width of one frame dimension register.
    localparam int DIM_BITS      = 16;
    // Cursor width: holds the sum of three dimension registers.
    localparam int POS_BITS      = DIM_BITS + 2;
    localparam int GREY_BITS     = 8;
    localparam int BYTE_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = DIM_BITS;
    // Bits per output byte, minus one: the last bit slot of a byte.
    localparam logic [2:0] LAST_BIT_SLOT = 3'd7;
    // Rounding term that pads a row to a whole byte.
    localparam logic [POS_BITS-1:0] PAD_ROUND = POS_BITS'(7);

    // Opcodes of an input transaction.
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_INNER_WIDTH    = 3'd0,
        REG_INNER_HEIGHT   = 3'd1,
        REG_LEFT_MARGIN    = 3'd2,
        REG_RIGHT_MARGIN   = 3'd3,
        REG_TOP_MARGIN     = 3'd4,
        REG_BOTTOM_MARGIN  = 3'd5,
        REG_GREY_THRESHOLD = 3'd6,
        REG_STRIPE_ENABLE  = 3'd7
    } t_cfg_index;

    // Configuration registers plus the frame geometry derived from them.
    typedef struct packed {
        logic [DIM_BITS-1:0]  inner_width;
        logic [DIM_BITS-1:0]  inner_height;
        logic [DIM_BITS-1:0]  left_margin;
        logic [DIM_BITS-1:0]  right_margin;
        logic [DIM_BITS-1:0]  top_margin;
        logic [DIM_BITS-1:0]  bottom_margin;
        logic [GREY_BITS-1:0] grey_threshold;
        logic                 stripe_enable;
        logic [POS_BITS-1:0]  padded_width;
        logic [POS_BITS-1:0]  frame_rows;
        logic                 frame_empty;
    } t_geom;

    // Result of one transaction, with the cursor it leaves behind.
    typedef struct packed {
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] packed_byte;
        logic                 end_of_frame;
        logic                 rejected;
        logic [POS_BITS-1:0]  next_row;
        logic [POS_BITS-1:0]  next_bit;
    } t_result;

    // True when the cursor position lies inside the source image.
    function automatic logic is_pixel(
        input logic [POS_BITS-1:0] row,
        input logic [POS_BITS-1:0] bitp,
        input t_geom               geom
    );
        logic [POS_BITS-1:0] top_ext;
        logic [POS_BITS-1:0] left_ext;
        logic                row_in;
        logic                col_in;
        top_ext  = POS_BITS'(geom.top_margin);
        left_ext = POS_BITS'(geom.left_margin);
        row_in   = (row >= top_ext) &&
                   ((row - top_ext) < POS_BITS'(geom.inner_height));
        col_in   = (bitp >= left_ext) &&
                   ((bitp - left_ext) < POS_BITS'(geom.inner_width));
        return row_in && col_in;
    endfunction

endpackage

@@ design/gtbp_cfg_regs.sv @@
// Configuration registers of the bit packer and the frame geometry derived from them.
// Depends on gtbp_pkg.
`timescale 1ns / 1ps

module gtbp_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [gtbp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [gtbp_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    output gtbp_pkg::t_geom                    o_geom
);
    import gtbp_pkg::*;

    logic [DIM_BITS-1:0]  r_inner_width;
    logic [DIM_BITS-1:0]  r_inner_height;
    logic [DIM_BITS-1:0]  r_left_margin;
    logic [DIM_BITS-1:0]  r_right_margin;
    logic [DIM_BITS-1:0]  r_top_margin;
    logic [DIM_BITS-1:0]  r_bottom_margin;
    logic [GREY_BITS-1:0] r_grey_threshold;
    logic                 r_stripe_enable;

    logic [POS_BITS-1:0]  row_width;
    logic [POS_BITS-1:0]  padded_width;
    logic [POS_BITS-1:0]  frame_rows;

    // Register writes; each register keeps only its own low bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_width    <= '0;
            r_inner_height   <= '0;
            r_left_margin    <= '0;
            r_right_margin   <= '0;
            r_top_margin     <= '0;
            r_bottom_margin  <= '0;
            r_grey_threshold <= GREY_BITS'(127);
            r_stripe_enable  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                REG_INNER_WIDTH:    r_inner_width    <= i_cfg_wdata[DIM_BITS-1:0];
                REG_INNER_HEIGHT:   r_inner_height   <= i_cfg_wdata[DIM_BITS-1:0];
                REG_LEFT_MARGIN:    r_left_margin    <= i_cfg_wdata[DIM_BITS-1:0];
                REG_RIGHT_MARGIN:   r_right_margin   <= i_cfg_wdata[DIM_BITS-1:0];
                REG_TOP_MARGIN:     r_top_margin     <= i_cfg_wdata[DIM_BITS-1:0];
                REG_BOTTOM_MARGIN:  r_bottom_margin  <= i_cfg_wdata[DIM_BITS-1:0];
                REG_GREY_THRESHOLD: r_grey_threshold <= i_cfg_wdata[GREY_BITS-1:0];
                REG_STRIPE_ENABLE:  r_stripe_enable  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Row width rounded up to a whole byte, and total frame rows.
    always_comb begin
        row_width    = POS_BITS'(r_left_margin) + POS_BITS'(r_inner_width) +
                       POS_BITS'(r_right_margin);
        padded_width = (row_width + PAD_ROUND) & ~PAD_ROUND;
        frame_rows   = POS_BITS'(r_top_margin) + POS_BITS'(r_inner_height) +
                       POS_BITS'(r_bottom_margin);
    end

    assign o_geom.inner_width    = r_inner_width;
    assign o_geom.inner_height   = r_inner_height;
    assign o_geom.left_margin    = r_left_margin;
    assign o_geom.right_margin   = r_right_margin;
    assign o_geom.top_margin     = r_top_margin;
    assign o_geom.bottom_margin  = r_bottom_margin;
    assign o_geom.grey_threshold = r_grey_threshold;
    assign o_geom.stripe_enable  = r_stripe_enable;
    assign o_geom.padded_width   = padded_width;
    assign o_geom.frame_rows     = frame_rows;
    assign o_geom.frame_empty    = (padded_width == '0) || (frame_rows == '0);

endmodule

@@ design/gtbp_core.sv @@
// Cursor, bit accumulator and per-transaction result logic of the bit packer.
// Depends on gtbp_pkg.
`timescale 1ns / 1ps

module gtbp_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic                           i_opcode,
    input  logic [gtbp_pkg::GREY_BITS-1:0] i_grey,
    input  gtbp_pkg::t_geom                i_geom,
    output gtbp_pkg::t_result              o_result
);
    import gtbp_pkg::*;

    logic [POS_BITS-1:0]  r_row;
    logic [POS_BITS-1:0]  r_bit;
    logic [BYTE_BITS-1:0] r_acc;
    logic [POS_BITS-1:0]  n_row;
    logic [POS_BITS-1:0]  n_bit;
    logic [BYTE_BITS-1:0] n_acc;

    logic pix;
    logic rejected;
    logic stripe_row;
    logic new_bit;
    logic row_end;
    logic frame_end;
    logic byte_done;

    // Classify the current position and pick the bit that fills it.
    always_comb begin
        pix        = is_pixel(r_row, r_bit, i_geom);
        rejected   = i_geom.frame_empty || (pix != (i_opcode == OP_PIXEL));
        stripe_row = i_geom.stripe_enable && (i_geom.bottom_margin != '0) &&
                     (r_row == (i_geom.frame_rows - POS_BITS'(1)));
        if (pix) begin
            new_bit = (i_grey > i_geom.grey_threshold);
        end else begin
            new_bit = !stripe_row;
        end
        n_acc     = {r_acc[BYTE_BITS-2:0], new_bit};
        row_end   = ({1'b0, r_bit} + (POS_BITS+1)'(1)) >= {1'b0, i_geom.padded_width};
        frame_end = row_end &&
                    (({1'b0, r_row} + (POS_BITS+1)'(1)) >= {1'b0, i_geom.frame_rows});
        byte_done = !rejected && (r_bit[2:0] == LAST_BIT_SLOT);
    end

    // Cursor advance with wrap at the row and frame edges.
    always_comb begin
        n_row = r_row;
        n_bit = r_bit;
        if (!rejected) begin
            if (row_end) begin
                n_bit = '0;
                n_row = frame_end ? '0 : (r_row + POS_BITS'(1));
            end else begin
                n_bit = r_bit + POS_BITS'(1);
            end
        end
    end

    // State updates only on accepted, matching transactions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_bit <= '0;
            r_acc <= '0;
        end else if (i_fire && !rejected) begin
            r_row <= n_row;
            r_bit <= n_bit;
            r_acc <= n_acc;
        end
    end

    assign o_result.byte_valid   = byte_done;
    assign o_result.packed_byte  = byte_done ? n_acc : '0;
    assign o_result.end_of_frame = byte_done && frame_end;
    assign o_result.rejected     = rejected;
    assign o_result.next_row     = n_row;
    assign o_result.next_bit     = n_bit;

    // A rejected or idle cycle leaves the cursor and accumulator untouched.
    a_hold_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_fire || rejected) |=> ($stable(r_row) && $stable(r_bit) && $stable(r_acc)))
        else $error("cursor moved without an accepted matching transaction");

    // An empty frame rejects everything.
    a_empty_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_geom.frame_empty) |-> (rejected && !byte_done))
        else $error("transaction accepted on an empty frame");

    // Inside a row the bit position steps by exactly one.
    a_bit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !rejected && !row_end) |=>
            (r_bit == $past(r_bit) + POS_BITS'(1)) && (r_row == $past(r_row)))
        else $error("bit position did not step by one");

    // A completed frame always returns the cursor to the top left corner.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !rejected && frame_end) |=> (r_row == '0 && r_bit == '0))
        else $error("cursor did not wrap at the end of the frame");

endmodule

@@ design/grey_threshold_bit_packer_top.sv @@
// Top level of the grey threshold bit packer: input register, core and result register.
// Depends on gtbp_pkg, gtbp_cfg_regs and gtbp_core.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+----------------------------------------
//  in       | sink      | i_in_valid / o_in_stall   | i_opcode, i_grey
//  out      | source    | o_out_valid / i_out_stall | o_byte_valid, o_packed_byte,
//           |           |                           | o_end_of_frame, o_want_pixel, o_rejected
//  cfg      | sink      | i_cfg_wr_en               | i_cfg_index, i_cfg_wdata
//
// One transaction enters per cycle unless a stalled result holds the input register back.
// Each one passes the input register, then the result register; the single cursor update loop sets the throughput.
// Synchronous active-low reset clears the cursor, the accumulator and both valid flags.
// A stalled result holds; the input register still takes one more transaction behind it.
`timescale 1ns / 1ps

module grey_threshold_bit_packer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [gtbp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [gtbp_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic [gtbp_pkg::GREY_BITS-1:0]     i_grey,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_byte_valid,
    output logic [gtbp_pkg::BYTE_BITS-1:0]     o_packed_byte,
    output logic                               o_end_of_frame,
    output logic                               o_want_pixel,
    output logic                               o_rejected
);
    import gtbp_pkg::*;

    t_geom                geom;
    t_result              core_result;
    t_result              r_out;
    logic                 r_out_valid;
    logic                 r_in_valid;
    logic                 r_in_opcode;
    logic [GREY_BITS-1:0] r_in_grey;
    logic                 proc_go;
    logic                 in_accept;

    gtbp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_geom      (geom)
    );

    gtbp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_go),
        .i_opcode (r_in_opcode),
        .i_grey   (r_in_grey),
        .i_geom   (geom),
        .o_result (core_result)
    );

    // The held transaction moves on whenever the result register is free or draining.
    assign proc_go    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !proc_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_opcode <= i_opcode;
            r_in_grey   <= i_grey;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go) begin
            r_out <= core_result;
        end
    end

    // The pixel request looks at the cursor this transaction left behind.
    assign o_out_valid    = r_out_valid;
    assign o_byte_valid   = r_out.byte_valid;
    assign o_packed_byte  = r_out.packed_byte;
    assign o_end_of_frame = r_out.end_of_frame;
    assign o_rejected     = r_out.rejected;
    assign o_want_pixel   = !geom.frame_empty &&
                            is_pixel(r_out.next_row, r_out.next_bit, geom);

endmodule

@@ dv/grey_threshold_bit_packer_top_tb.sv @@
// Self-checking testbench for grey_threshold_bit_packer_top: directed and random transactions
// checked against a cycle-free predictor of the bit packer. Depends on gtbp_pkg and the top level.
`timescale 1ns / 1ps

module grey_threshold_bit_packer_top_tb;

    import gtbp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned RANDOM_ITEMS  = 1150;
    localparam int unsigned REPORT_LIMIT  = 100;

    // One predicted output of the packer.
    typedef struct packed {
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] packed_byte;
        logic                 end_of_frame;
        logic                 want_pixel;
        logic                 rejected;
    } t_packer_out;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_opcode;
    logic [GREY_BITS-1:0]     i_grey;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic                     o_byte_valid;
    logic [BYTE_BITS-1:0]     o_packed_byte;
    logic                     o_end_of_frame;
    logic                     o_want_pixel;
    logic                     o_rejected;

    // Predictor copy of the configuration registers.
    logic [DIM_BITS-1:0]  width_px;
    logic [DIM_BITS-1:0]  height_px;
    logic [DIM_BITS-1:0]  margin_l;
    logic [DIM_BITS-1:0]  margin_r;
    logic [DIM_BITS-1:0]  margin_t;
    logic [DIM_BITS-1:0]  margin_b;
    logic [GREY_BITS-1:0] threshold;
    logic                 stripe_on;

    // Predictor copy of the cursor and the byte being assembled.
    logic [POS_BITS-1:0]  cur_row;
    logic [POS_BITS-1:0]  cur_col;
    logic [BYTE_BITS-1:0] bit_shift;

    t_packer_out          predicted_outputs[$];
    t_packer_out          oldest;
    int unsigned          advanced_count = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          result_index   = 0;
    int unsigned          cycle_count    = 0;
    logic                 steady_phase   = 1'b0;
    int unsigned          stall_hold     = 0;
    int unsigned          stall_pick;

    grey_threshold_bit_packer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_grey         (i_grey),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_valid   (o_byte_valid),
        .o_packed_byte  (o_packed_byte),
        .o_end_of_frame (o_end_of_frame),
        .o_want_pixel   (o_want_pixel),
        .o_rejected     (o_rejected)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver back-pressure: mostly short stalls, now and then a long one.
    always @(negedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (steady_phase || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(0, 6);
            end else if (stall_pick < 93) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(8, 30);
            end
        end
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] wanted);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                     $time, result_index, field, got, wanted);
        end
        mismatch_count++;
    endtask

    // Compare every accepted result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_index++;
            if (predicted_outputs.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_packed_byte), 32'd0);
            end else begin
                oldest = predicted_outputs.pop_front();
                if (o_byte_valid !== oldest.byte_valid)
                    report_mismatch("byte_valid", 32'(o_byte_valid), 32'(oldest.byte_valid));
                if (o_packed_byte !== oldest.packed_byte)
                    report_mismatch("packed_byte", 32'(o_packed_byte), 32'(oldest.packed_byte));
                if (o_end_of_frame !== oldest.end_of_frame)
                    report_mismatch("end_of_frame", 32'(o_end_of_frame),
                                    32'(oldest.end_of_frame));
                if (o_want_pixel !== oldest.want_pixel)
                    report_mismatch("want_pixel", 32'(o_want_pixel), 32'(oldest.want_pixel));
                if (o_rejected !== oldest.rejected)
                    report_mismatch("rejected", 32'(o_rejected), 32'(oldest.rejected));
            end
        end
    end

    // Row width with margins, rounded up to whole bytes.
    function automatic logic [POS_BITS-1:0] padded_row_bits();
        logic [POS_BITS-1:0] w;
        w = POS_BITS'(margin_l) + POS_BITS'(width_px) + POS_BITS'(margin_r);
        return (w + POS_BITS'(7)) & ~POS_BITS'(7);
    endfunction

    function automatic logic [POS_BITS-1:0] frame_row_count();
        return POS_BITS'(margin_t) + POS_BITS'(height_px) + POS_BITS'(margin_b);
    endfunction

    function automatic logic in_image(logic [POS_BITS-1:0] row, logic [POS_BITS-1:0] col);
        logic [POS_BITS-1:0] top_p;
        logic [POS_BITS-1:0] left_p;
        top_p  = POS_BITS'(margin_t);
        left_p = POS_BITS'(margin_l);
        return (row >= top_p) && ((row - top_p) < POS_BITS'(height_px)) &&
               (col >= left_p) && ((col - left_p) < POS_BITS'(width_px));
    endfunction

    // Threshold one position, shift it into the byte and move the cursor.
    function automatic t_packer_out pack_one_position(logic op, logic [GREY_BITS-1:0] grey);
        t_packer_out         res;
        logic [POS_BITS-1:0] wp;
        logic [POS_BITS-1:0] rows;
        logic                on_pixel;
        logic                px_bit;
        logic                row_end;
        logic                frame_end;
        res  = '0;
        wp   = padded_row_bits();
        rows = frame_row_count();
        if (wp == 0 || rows == 0) begin
            res.rejected = 1'b1;
        end else begin
            on_pixel = in_image(cur_row, cur_col);
            if (on_pixel != (op == OP_PIXEL)) begin
                res.rejected = 1'b1;
            end else begin
                // Pixels are thresholded; margins are white unless on the stripe row.
                if (on_pixel)
                    px_bit = (grey > threshold);
                else
                    px_bit = !(stripe_on && margin_b != 0 && cur_row == rows - 1'b1);
                bit_shift = {bit_shift[BYTE_BITS-2:0], px_bit};
                row_end   = (cur_col + 32'd1) >= wp;
                frame_end = row_end && ((cur_row + 32'd1) >= rows);
                if (cur_col[2:0] == LAST_BIT_SLOT) begin
                    res.byte_valid   = 1'b1;
                    res.packed_byte  = bit_shift;
                    res.end_of_frame = frame_end;
                end
                if (row_end) begin
                    cur_col = '0;
                    cur_row = frame_end ? '0 : cur_row + 1'b1;
                end else begin
                    cur_col = cur_col + 1'b1;
                end
                advanced_count++;
            end
            res.want_pixel = in_image(cur_row, cur_col);
        end
        return res;
    endfunction

    // Opcode that the cursor position calls for.
    function automatic logic fitting_opcode();
        return in_image(cur_row, cur_col) ? OP_PIXEL : OP_ADVANCE;
    endfunction

    function automatic int unsigned pick_in_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one transaction after a random gap and wait for it to be taken.
    task automatic send_item(logic op, logic [GREY_BITS-1:0] grey);
        int unsigned gap;
        gap = pick_in_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_grey     <= grey;
        do @(posedge i_clk); while (o_in_stall);
        predicted_outputs.push_back(pack_one_position(op, grey));
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_INNER_WIDTH:    width_px  = value;
            REG_INNER_HEIGHT:   height_px = value;
            REG_LEFT_MARGIN:    margin_l  = value;
            REG_RIGHT_MARGIN:   margin_r  = value;
            REG_TOP_MARGIN:     margin_t  = value;
            REG_BOTTOM_MARGIN:  margin_b  = value;
            REG_GREY_THRESHOLD: threshold = value[GREY_BITS-1:0];
            REG_STRIPE_ENABLE:  stripe_on = value[0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [DIM_BITS-1:0] w, h, l, r, t, b);
        write_reg(REG_INNER_WIDTH, w);
        write_reg(REG_INNER_HEIGHT, h);
        write_reg(REG_LEFT_MARGIN, l);
        write_reg(REG_RIGHT_MARGIN, r);
        write_reg(REG_TOP_MARGIN, t);
        write_reg(REG_BOTTOM_MARGIN, b);
    endtask

    // With no frame, every transaction is refused whatever its opcode.
    task automatic test_empty_frame();
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_ADVANCE, 8'hFF);
        drain_results();
        write_reg(REG_INNER_HEIGHT, 16'd1);
        send_item(OP_ADVANCE, 8'h5A);
        drain_results();
        write_reg(REG_INNER_HEIGHT, 16'd0);
        write_reg(REG_INNER_WIDTH, 16'd8);
        send_item(OP_PIXEL, 8'hA5);
    endtask

    // Lowest and highest threshold, plus a wrong opcode on a pixel and on a margin bit.
    task automatic test_threshold_extremes();
        drain_results();
        set_frame(16'd4, 16'd1, 16'd0, 16'd4, 16'd0, 16'd0);
        // Upper data bits must not reach the 8-bit threshold.
        write_reg(REG_GREY_THRESHOLD, 16'hA500);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_PIXEL, 8'h01);
        send_item(OP_ADVANCE, 8'h80);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'h00);
        repeat (4) send_item(OP_ADVANCE, 8'h00);
        drain_results();
        write_reg(REG_GREY_THRESHOLD, 16'h5AFF);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'hFE);
        send_item(OP_PIXEL, 8'h80);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_PIXEL, 8'h7F);
        repeat (4) send_item(OP_ADVANCE, 8'hFF);
    endtask

    // A single bottom row with the stripe on comes out black, pad bits included.
    task automatic test_bottom_stripe();
        drain_results();
        set_frame(16'd0, 16'd0, 16'd0, 16'd3, 16'd1, 16'd1);
        write_reg(REG_STRIPE_ENABLE, 16'hFFFF);
        repeat (16) send_item(fitting_opcode(), 8'($urandom));
        drain_results();
        write_reg(REG_STRIPE_ENABLE, 16'hFFFE);
    endtask

    // Every dimension at its maximum; only the top left corner is walked.
    task automatic test_extreme_geometry();
        drain_results();
        set_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (3) send_item(fitting_opcode(), 8'($urandom));
        send_item(OP_PIXEL, 8'hFF);
        repeat (3) send_item(fitting_opcode(), 8'($urandom));
    endtask

    // Shrink the frame under the cursor, first past the row end, then past the last row.
    task automatic test_cursor_outside_frame();
        drain_results();
        set_frame(16'd2, 16'd1, 16'd12, 16'd2, 16'd0, 16'd0);
        for (int k = 0; k < 64 && cur_col != 13; k++)
            send_item(fitting_opcode(), 8'($urandom));
        drain_results();
        // The cursor now sits beyond the 8-bit row and counts as a pad bit.
        set_frame(16'd2, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_ADVANCE, 8'h00);
        drain_results();
        set_frame(16'd2, 16'd1, 16'd0, 16'd6, 16'd2, 16'd0);
        for (int k = 0; k < 64 && cur_row != 1; k++)
            send_item(fitting_opcode(), 8'($urandom));
        drain_results();
        // Row one is now past the last row and is walked as a white row.
        write_reg(REG_TOP_MARGIN, 16'd0);
        repeat (8) send_item(fitting_opcode(), 8'($urandom));
    endtask

    function automatic logic [DIM_BITS-1:0] rand_dim(int unsigned limit);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 95)
            return DIM_BITS'($urandom_range(0, limit));
        if (r < 98)
            return 16'hFFFF;
        return DIM_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic logic [GREY_BITS-1:0] rand_threshold();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Mostly the opcode the cursor expects, some flipped and some fully random.
    function automatic logic random_opcode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return fitting_opcode();
        if (r < 96)
            return !fitting_opcode();
        return 1'($urandom);
    endfunction

    function automatic logic [GREY_BITS-1:0] random_grey();
        if ($urandom_range(0, 99) < 15)
            return threshold + 8'($urandom_range(0, 1));
        return 8'($urandom);
    endfunction

    // Random frames, each walked for a while without realigning the cursor.
    task automatic test_random_frames();
        int unsigned start;
        int unsigned phase_len;
        start = advanced_count;
        while (advanced_count - start < RANDOM_ITEMS) begin
            drain_results();
            steady_phase = ($urandom_range(0, 4) == 0);
            set_frame(rand_dim(24), rand_dim(4), rand_dim(9), rand_dim(9),
                      rand_dim(3), rand_dim(3));
            write_reg(REG_GREY_THRESHOLD, {8'($urandom), rand_threshold()});
            write_reg(REG_STRIPE_ENABLE, {15'($urandom), 1'($urandom)});
            phase_len = $urandom_range(40, 160);
            repeat (phase_len) begin
                // Occasionally hold off until the pipeline is empty.
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                send_item(random_opcode(), random_grey());
            end
        end
        steady_phase = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_INNER_WIDTH;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_PIXEL;
        i_grey      = '0;
        i_out_stall = 1'b0;
        width_px    = '0;
        height_px   = '0;
        margin_l    = '0;
        margin_r    = '0;
        margin_t    = '0;
        margin_b    = '0;
        threshold   = 8'd127;
        stripe_on   = 1'b0;
        cur_row     = '0;
        cur_col     = '0;
        bit_shift   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_frame();
        test_threshold_extremes();
        test_bottom_stripe();
        test_extreme_geometry();
        test_cursor_outside_frame();
        test_random_frames();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
design/gtbp_pkg.sv
design/gtbp_cfg_regs.sv
design/gtbp_core.sv
design/grey_threshold_bit_packer_top.sv
dv/grey_threshold_bit_packer_top_tb.sv
